// ----- rtl/core/separable_5x5_blur_defines.svh -----
// Assertion macros shared by the blur RTL
`ifndef SEPARABLE_5X5_BLUR_DEFINES_SVH
`define SEPARABLE_5X5_BLUR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset
`define SBL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbl: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset
`define SBL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbl: next-cycle check failed");

`else

`define SBL_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SBL_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/sbl_pkg.sv -----
// Shared constants and types of the 5x5 blur
`default_nettype none

package sbl_pkg;

    // Line memory geometry
    localparam int MAX_WIDTH   = 1024;
    localparam int KERNEL_SIZE = 5;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int LANES       = KERNEL_SIZE - 1;
    localparam int SLOT_W      = $clog2(LANES);

    // Frame size registers and counters
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 12;
    localparam int ROW_W    = 12;
    localparam int MIN_SIZE = 5;
    localparam int CMP_W    = ((COL_W > WIDTH_W) ? COL_W : WIDTH_W) + 1;
    localparam int RCMP_W   = ROW_W + 1;

    // Pixel layout: channel 0 blue, 1 green, 2 red
    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;

    // Kernel weights 1 2 4 2 1 as left shifts
    localparam int TAP_SHIFT [KERNEL_SIZE] = '{0, 1, 2, 1, 0};

    // Sum widths: column sum up to 10*255, full sum up to 100*255
    localparam int VSUM_W = 12;
    localparam int HSUM_W = 15;

    // Divide by 100: multiply by ceil(2^22 / 100) and take bits above 22
    localparam int                RECIP_W     = 16;
    localparam int                RECIP_SHIFT = 22;
    localparam logic [RECIP_W-1:0] RECIP      = 16'd41944;
    localparam int                PROD_W      = HSUM_W + RECIP_W;

    // Item codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef logic [CH_W-1:0] t_chan;
    typedef t_chan [NUM_CH-1:0] t_pixel;
    typedef t_pixel [LANES-1:0] t_line;

    // Per-item control leaving the sequencer
    typedef struct packed {
        logic              shift;
        logic              emit;
        logic              inner;
        logic              frame_end;
        logic [SLOT_W-1:0] slot;
    } t_ctrl;

    // Control that travels with the filter stages
    typedef struct packed {
        logic emit;
        logic inner;
        logic frame_end;
    } t_tag;

    // One result word
    typedef struct packed {
        t_pixel pix;
        logic   frame_end;
    } t_res;

endpackage

`default_nettype wire

// ----- rtl/core/sbl_if.sv -----
// Stream interfaces for source pixels and blurred pixels
`default_nettype none

interface sbl_in_if;
    import sbl_pkg::*;

    logic            valid;
    logic            ready;
    logic            op;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;

    modport source (output valid, op, blue, green, red, input ready);
    modport sink (input valid, op, blue, green, red, output ready);
endinterface

interface sbl_out_if;
    import sbl_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
    logic            frame_end;

    modport source (output valid, out_blue, out_green, out_red, frame_end, input ready);
    modport sink (input valid, out_blue, out_green, out_red, frame_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sbl_line_mem.sv -----
// Four-row line memory, one lane per row, registered read
`default_nettype none

module sbl_line_mem (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [sbl_pkg::COL_W-1:0]  i_addr,
    input  logic                       i_wr_en,
    input  logic [sbl_pkg::SLOT_W-1:0] i_wr_lane,
    input  sbl_pkg::t_pixel            i_wr_data,
    output sbl_pkg::t_line             o_rd_data
);
    import sbl_pkg::*;

    t_line r_mem [MAX_WIDTH];
    t_line r_rd_data;

    // Read the whole column, write one lane; a same-address read sees the old word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr][i_wr_lane] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/core/sbl_seq.sv -----
// Raster counters, drain control and line memory addressing
`default_nettype none
`include "separable_5x5_blur_defines.svh"

module sbl_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic                         i_op,
    input  sbl_pkg::t_pixel              i_pixel,
    input  logic [sbl_pkg::WIDTH_W-1:0]  i_image_width,
    input  logic [sbl_pkg::HEIGHT_W-1:0] i_image_height,
    output logic [sbl_pkg::COL_W-1:0]    o_mem_addr,
    output logic                         o_mem_wr_en,
    output logic [sbl_pkg::SLOT_W-1:0]   o_mem_lane,
    output sbl_pkg::t_ctrl               o_s1_ctrl,
    output sbl_pkg::t_pixel              o_s1_pixel
);
    import sbl_pkg::*;

    logic [COL_W-1:0]  r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [SLOT_W-1:0] r_slot;
    logic              r_done;
    t_ctrl             r_s1_ctrl;
    t_pixel            r_s1_pixel;

    logic [COL_W-1:0]  n_in_col;
    logic [ROW_W-1:0]  n_in_row;
    logic [COL_W-1:0]  n_out_col;
    logic [ROW_W-1:0]  n_out_row;
    logic [SLOT_W-1:0] n_slot;
    logic              n_done;

    logic [CMP_W-1:0]    w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic                accept;
    logic                px_take;
    logic                drain;
    logic                shift;
    logic                go;
    logic                emit;
    logic                col_last;
    logic                row_last;
    logic                ocol_last;
    logic                orow_last;
    logic                inner;
    logic                frame_end;

    // Clamp the frame size to the supported range
    always_comb begin
        if (CMP_W'(i_image_width) < CMP_W'(MIN_SIZE)) begin
            w_eff = CMP_W'(MIN_SIZE);
        end else if (CMP_W'(i_image_width) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = CMP_W'(i_image_width);
        end
        h_eff = (i_image_height < HEIGHT_W'(MIN_SIZE)) ? HEIGHT_W'(MIN_SIZE) : i_image_height;
    end

    // Classify the word and find the edges of the frame
    assign accept  = i_en & i_valid;
    assign px_take = accept & (i_op == OP_PIXEL) & ~r_done;
    assign drain   = accept & (i_op == OP_DRAIN) & r_done;
    assign shift   = px_take | drain;
    assign go      = px_take & ((r_in_row >= ROW_W'(3)) |
                                ((r_in_row == ROW_W'(2)) & (r_in_col >= COL_W'(2))));
    assign emit    = go | drain;

    assign col_last  = (CMP_W'(r_in_col) + CMP_W'(1)) >= w_eff;
    assign row_last  = (RCMP_W'(r_in_row) + RCMP_W'(1)) >= RCMP_W'(h_eff);
    assign ocol_last = (CMP_W'(r_out_col) + CMP_W'(1)) >= w_eff;
    assign orow_last = (RCMP_W'(r_out_row) + RCMP_W'(1)) >= RCMP_W'(h_eff);
    assign frame_end = ocol_last & orow_last;

    // Output pixel lies at least two away from every border
    assign inner = (r_out_row >= ROW_W'(2)) &&
                   ((RCMP_W'(r_out_row) + RCMP_W'(2)) < RCMP_W'(h_eff)) &&
                   (r_out_col >= COL_W'(2)) &&
                   ((CMP_W'(r_out_col) + CMP_W'(2)) < w_eff);

    // Advance the input and output raster positions
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_slot    = r_slot;
        n_done    = r_done;
        if (shift) begin
            if (col_last) begin
                n_in_col = '0;
                n_slot   = r_slot + SLOT_W'(1);
                if (px_take) begin
                    if (row_last) begin
                        n_in_row = '0;
                        n_done   = 1'b1;
                    end else begin
                        n_in_row = r_in_row + ROW_W'(1);
                    end
                end
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
        end
        if (emit) begin
            if (ocol_last) begin
                n_out_col = '0;
                if (orow_last) begin
                    // Last pixel of the frame: rewind for the next one
                    n_out_row = '0;
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_slot    = '0;
                    n_done    = 1'b0;
                end else begin
                    n_out_row = r_out_row + ROW_W'(1);
                end
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end
    end

    // Hold counters and the first pipeline stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_slot    <= '0;
            r_done    <= 1'b0;
            r_s1_ctrl <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_slot    <= n_slot;
            r_done    <= n_done;
            if (i_en) begin
                r_s1_ctrl <= '{shift:     shift,
                               emit:      emit,
                               inner:     inner & emit,
                               frame_end: frame_end & emit,
                               slot:      r_slot};
            end
        end
    end

    // Carry the new pixel alongside the memory read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_pixel <= i_pixel;
        end
    end

    assign o_mem_addr  = r_in_col;
    assign o_mem_wr_en = px_take;
    assign o_mem_lane  = r_slot;
    assign o_s1_ctrl   = r_s1_ctrl;
    assign o_s1_pixel  = r_s1_pixel;

    `SBL_ASSERT_IMP(a_done_row_clear, i_clk, i_rst_n, r_done, r_in_row == '0)
    `SBL_ASSERT_IMP(a_emit_needs_shift, i_clk, i_rst_n, r_s1_ctrl.emit, r_s1_ctrl.shift)
    `SBL_ASSERT_NXT(a_stall_holds_pos, i_clk, i_rst_n, !i_en, $stable(r_in_col) && $stable(r_slot))

endmodule

`default_nettype wire

// ----- rtl/core/sbl_filter.sv -----
// Column sums, row sum and divide by the kernel weight
`default_nettype none

module sbl_filter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  sbl_pkg::t_ctrl  i_ctrl,
    input  sbl_pkg::t_pixel i_pixel,
    input  sbl_pkg::t_line  i_line,
    output logic            o_emit,
    output sbl_pkg::t_res   o_res
);
    import sbl_pkg::*;

    // Only the centre column onwards is needed for border copy
    localparam int CTR_DEPTH = KERNEL_SIZE / 2 + 1;

    t_pixel            row_px [KERNEL_SIZE];
    logic [VSUM_W-1:0] vsum_new [NUM_CH];
    logic [HSUM_W-1:0] hsum [NUM_CH];

    logic [VSUM_W-1:0] r_vsum [KERNEL_SIZE][NUM_CH];
    t_pixel            r_ctr [CTR_DEPTH];
    t_tag              r_col_tag;
    t_tag              r_sum_tag;
    t_tag              r_prod_tag;
    logic [HSUM_W-1:0] r_hsum [NUM_CH];
    t_pixel            r_sum_ctr;
    logic [PROD_W-1:0] r_prod [NUM_CH];
    t_pixel            r_prod_ctr;

    // Put the stored rows in window order, oldest on top
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            row_px[i] = i_line[SLOT_W'(i_ctrl.slot + SLOT_W'(i))];
        end
        row_px[KERNEL_SIZE-1] = i_pixel;
    end

    // Weight the incoming column
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            vsum_new[c] = '0;
            for (int k = 0; k < KERNEL_SIZE; k++) begin
                vsum_new[c] = vsum_new[c] + (VSUM_W'(row_px[k][c]) << TAP_SHIFT[k]);
            end
        end
    end

    // Weight the five column sums across the window
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            hsum[c] = '0;
            for (int k = 0; k < KERNEL_SIZE; k++) begin
                hsum[c] = hsum[c] + (HSUM_W'(r_vsum[k][c]) << TAP_SHIFT[k]);
            end
        end
    end

    // Slide the window one column
    always_ff @(posedge i_clk) begin
        if (i_en && i_ctrl.shift) begin
            for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
                r_vsum[j] <= r_vsum[j+1];
            end
            r_vsum[KERNEL_SIZE-1] <= vsum_new;
            for (int j = 0; j < CTR_DEPTH - 1; j++) begin
                r_ctr[j] <= r_ctr[j+1];
            end
            r_ctr[CTR_DEPTH-1] <= row_px[KERNEL_SIZE/2];
        end
    end

    // Advance the stage tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_tag  <= '0;
            r_sum_tag  <= '0;
            r_prod_tag <= '0;
        end else if (i_en) begin
            r_col_tag  <= '{emit: i_ctrl.emit, inner: i_ctrl.inner,
                            frame_end: i_ctrl.frame_end};
            r_sum_tag  <= r_col_tag;
            r_prod_tag <= r_sum_tag;
        end
    end

    // Register the window sum, then the reciprocal product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hsum     <= hsum;
            r_sum_ctr  <= r_ctr[0];
            r_prod_ctr <= r_sum_ctr;
            for (int c = 0; c < NUM_CH; c++) begin
                r_prod[c] <= PROD_W'(r_hsum[c]) * PROD_W'(RECIP);
            end
        end
    end

    // Blur inside, copy the centre pixel near the border
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            o_res.pix[c] = r_prod_tag.inner ? r_prod[c][RECIP_SHIFT +: CH_W] : r_prod_ctr[c];
        end
        o_res.frame_end = r_prod_tag.frame_end;
    end

    assign o_emit = r_prod_tag.emit;

endmodule

`default_nettype wire

// ----- rtl/core/separable_5x5_blur.sv -----
// Top level of the streaming 5x5 blur: APB registers, pipeline and output skid buffer
// A result word passes the sequencer stage, the column-sum, window-sum and product
// registers and the output register (the stream lags by two rows and two columns).
// Throughput: one word per cycle while the skid stage is empty; the line memory takes one
// column read and at most one lane write per cycle. Reset: synchronous, active low;
// counters, valids and sizes (640x480) reset, line memory contents are left as they are.
`default_nettype none
`include "separable_5x5_blur_defines.svh"

module separable_5x5_blur (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    sbl_in_if.sink                    i_pix,
    sbl_out_if.source                 o_pix,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import sbl_pkg::*;

    localparam int   APB_DATA_W = 32;
    localparam int   REG_SEL    = 2;
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [WIDTH_W-1:0]  r_image_width;
    logic [HEIGHT_W-1:0] r_image_height;
    logic                r_out_valid;
    t_res                r_out;
    logic                r_skid_valid;
    t_res                r_skid;

    logic               apb_wr;
    logic               reg_idx;
    logic               en;
    logic               push;
    t_pixel             in_pixel;
    logic [COL_W-1:0]   mem_addr;
    logic               mem_wr_en;
    logic [SLOT_W-1:0]  mem_lane;
    t_line              mem_rd_data;
    t_ctrl              s1_ctrl;
    t_pixel             s1_pixel;
    logic               res_emit;
    t_res               res;

    // Register access
    assign apb_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[REG_SEL];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_W'(640);
            r_image_height <= HEIGHT_W'(480);
        end else if (apb_wr) begin
            unique case (reg_idx)
                REG_WIDTH:  r_image_width  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: r_image_height <= pwdata[HEIGHT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = APB_DATA_W'(r_image_width);
            REG_HEIGHT: prdata = APB_DATA_W'(r_image_height);
        endcase
    end

    // Pipeline moves whenever the skid stage is empty
    assign en          = ~r_skid_valid;
    assign i_pix.ready = en;
    assign in_pixel    = {i_pix.red, i_pix.green, i_pix.blue};

    sbl_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_pix.valid),
        .i_op           (i_pix.op),
        .i_pixel        (in_pixel),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_mem_addr     (mem_addr),
        .o_mem_wr_en    (mem_wr_en),
        .o_mem_lane     (mem_lane),
        .o_s1_ctrl      (s1_ctrl),
        .o_s1_pixel     (s1_pixel)
    );

    sbl_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (en),
        .i_addr    (mem_addr),
        .i_wr_en   (mem_wr_en),
        .i_wr_lane (mem_lane),
        .i_wr_data (in_pixel),
        .o_rd_data (mem_rd_data)
    );

    sbl_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctrl  (s1_ctrl),
        .i_pixel (s1_pixel),
        .i_line  (mem_rd_data),
        .o_emit  (res_emit),
        .o_res   (res)
    );

    // Output register with one skid word behind it
    assign push = en & res_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !o_pix.ready) begin
            // Output stalled: park a new word in the skid stage
            if (push) begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out        <= r_skid;
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else if (push) begin
            r_out       <= res;
            r_out_valid <= 1'b1;
        end else begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.out_blue  = r_out.pix[0];
    assign o_pix.out_green = r_out.pix[1];
    assign o_pix.out_red   = r_out.pix[2];
    assign o_pix.frame_end = r_out.frame_end;

    `SBL_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench of the 5x5 blur: directed frame, random small frames, size extremes
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sbl_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 12;
    localparam int RANDOM_WORDS    = 400;
    localparam int HOLD_CYCLES     = 400;
    localparam int WORDS_PER_PHASE = 64;
    localparam longint LIMIT_NS    = 20_000_000;

    // Register indexes and their reset values
    localparam int REG_WIDTH    = 0;
    localparam int REG_HEIGHT   = 1;
    localparam int NUM_REGS     = 2;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam int unsigned WEIGHT [KERNEL_SIZE] = '{1, 2, 4, 2, 1};
    localparam int unsigned KERNEL_SUM = 100;

    // Idle percentages per phase: none, sender, receiver, both
    localparam int IDLE_PCT  [4] = '{0, 46, 0, 7};
    localparam int STALL_PCT [4] = '{0, 0, 46, 7};

    // One line of the directed stimulus; want holds a pixel typed in by hand
    typedef struct packed {
        logic       op;
        t_pixel     pix;
        logic [7:0] reps;
        logic       fixed;
        t_pixel     want;
    } t_row;

    localparam int NUM_ROWS = 5;
    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        // drain before any pixel: ignored
        '{OP_DRAIN, 24'h3CA55A, 8'd1,  1'b0, 24'h000000},
        // whole 5x5 frame of red and blue at full scale, green at zero
        '{OP_PIXEL, 24'hFF00FF, 8'd25, 1'b1, 24'hFF00FF},
        // extra pixels once the frame is in: ignored
        '{OP_PIXEL, 24'h00FF00, 8'd2,  1'b0, 24'h000000},
        // flush the last two rows and two columns
        '{OP_DRAIN, 24'h00FF00, 8'd12, 1'b1, 24'hFF00FF},
        // drain after the frame has ended: ignored
        '{OP_DRAIN, 24'hFFFFFF, 8'd1,  1'b0, 24'h000000}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sbl_in_if  src_if ();
    sbl_out_if blur_if ();

    separable_5x5_blur dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (src_if),
        .o_pix   (blur_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Blur predictor state
    logic [WIDTH_W-1:0]  cfg_width  = WIDTH_W'(RESET_WIDTH);
    logic [HEIGHT_W-1:0] cfg_height = HEIGHT_W'(RESET_HEIGHT);
    t_pixel              line_mem [4*MAX_WIDTH] = '{default: '0};
    t_pixel              win [KERNEL_SIZE][KERNEL_SIZE] = '{default: '{default: '0}};
    logic [COL_W-1:0]    in_col  = '0;
    logic [ROW_W-1:0]    in_row  = '0;
    logic [COL_W-1:0]    out_col = '0;
    logic [ROW_W-1:0]    out_row = '0;
    logic [1:0]          slot    = '0;
    logic                in_done = 1'b0;

    // Blurred pixels still owed by the block, oldest first
    t_res   pending [$];
    bit     failed = 1'b0;

    // Sideband of the word on offer: a hand-typed pixel for its result
    logic   word_fixed;
    t_pixel word_want;

    int     words_sent = 0;
    int     idle_pct   = 0;
    int     stall_pct  = 0;
    int     hold_left  = 0;

    function automatic int unsigned eff_width();
        int unsigned w;
        w = cfg_width;
        if (w < MIN_SIZE) w = MIN_SIZE;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height < MIN_SIZE) ? MIN_SIZE : cfg_height;
    endfunction

    // Shift the window left and load the new column from the line store
    function automatic void shift_window(input t_pixel px, input bit store);
        int unsigned col;
        col = in_col % MAX_WIDTH;
        for (int i = 0; i < KERNEL_SIZE; i++)
            for (int j = 0; j < KERNEL_SIZE - 1; j++)
                win[i][j] = win[i][j+1];
        for (int i = 0; i < KERNEL_SIZE - 1; i++)
            win[i][KERNEL_SIZE-1] = line_mem[((slot + i) & 3) * MAX_WIDTH + col];
        win[KERNEL_SIZE-1][KERNEL_SIZE-1] = px;
        if (store)
            line_mem[slot * MAX_WIDTH + col] = px;
    endfunction

    // Advance the input column; only real pixels move the input row
    function automatic void advance_column(input bit real_px);
        if (in_col + 1 >= eff_width()) begin
            in_col = '0;
            slot   = slot + 2'd1;
            if (real_px) begin
                if (in_row + 1 >= eff_height()) begin
                    in_row  = '0;
                    in_done = 1'b1;
                end else begin
                    in_row = in_row + 1'b1;
                end
            end
        end else begin
            in_col = in_col + 1'b1;
        end
    endfunction

    // Blur or copy the window centre, then advance the output position
    function automatic t_res blurred_pixel();
        t_res        res;
        int unsigned w, h, acc;
        bit          inner;
        w = eff_width();
        h = eff_height();
        inner = out_row >= 2 && out_row + 2 < h && out_col >= 2 && out_col + 2 < w;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            acc = 0;
            for (int i = 0; i < KERNEL_SIZE; i++)
                for (int j = 0; j < KERNEL_SIZE; j++)
                    acc += WEIGHT[i] * WEIGHT[j] * win[i][j][ch];
            res.pix[ch] = inner ? t_chan'(acc / KERNEL_SUM) : win[2][2][ch];
        end
        res.frame_end = 1'b0;
        if (out_col + 1 >= w) begin
            out_col = '0;
            if (out_row + 1 >= h) begin
                res.frame_end = 1'b1;
                out_row = '0;
                in_col  = '0;
                in_row  = '0;
                slot    = '0;
                in_done = 1'b0;
            end else begin
                out_row = out_row + 1'b1;
            end
        end else begin
            out_col = out_col + 1'b1;
        end
        return res;
    endfunction

    // Predict the result of one accepted word; returns 1 when it yields one
    function automatic bit predict_word(input logic op, input t_pixel px, output t_res res);
        bit fire;
        if (op == OP_PIXEL) begin
            if (in_done) return 1'b0;
            fire = in_row >= 3 || (in_row == 2 && in_col >= 2);
            shift_window(px, 1'b1);
            advance_column(1'b1);
            if (!fire) return 1'b0;
            res = blurred_pixel();
            return 1'b1;
        end
        if (!in_done) return 1'b0;
        shift_window('0, 1'b0);
        advance_column(1'b0);
        res = blurred_pixel();
        return 1'b1;
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel px;
        for (int ch = 0; ch < NUM_CH; ch++)
            case ($urandom_range(5))
                0: px[ch] = '0;
                1: px[ch] = '1;
                default: px[ch] = t_chan'($urandom);
            endcase
        return px;
    endfunction

    // Predict on accepted input words, check accepted output words
    always @(posedge i_clk) begin : monitor
        t_res res;
        t_res want;
        if (i_rst_n) begin
            if (src_if.valid && src_if.ready) begin
                if (predict_word(src_if.op, {src_if.red, src_if.green, src_if.blue}, res)) begin
                    if (word_fixed) res.pix = word_want;
                    pending.insert(pending.size(), res);
                end
            end
            if (blur_if.valid && blur_if.ready) begin
                if (pending.size() == 0) begin
                    $error("blurred word with none expected: b %0d g %0d r %0d end %0b",
                           blur_if.out_blue, blur_if.out_green, blur_if.out_red,
                           blur_if.frame_end);
                    failed = 1'b1;
                end else begin
                    want = pending.pop_front();
                    if (blur_if.out_blue !== want.pix[0]) begin
                        $error("out_blue: expected %0d, got %0d", want.pix[0], blur_if.out_blue);
                        failed = 1'b1;
                    end
                    if (blur_if.out_green !== want.pix[1]) begin
                        $error("out_green: expected %0d, got %0d", want.pix[1],
                               blur_if.out_green);
                        failed = 1'b1;
                    end
                    if (blur_if.out_red !== want.pix[2]) begin
                        $error("out_red: expected %0d, got %0d", want.pix[2], blur_if.out_red);
                        failed = 1'b1;
                    end
                    if (blur_if.frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, got %0b", want.frame_end,
                               blur_if.frame_end);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    initial begin
        blur_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                blur_if.ready <= 1'b0;
                hold_left--;
            end else begin
                blur_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one word after a random gap and hold it until accepted
    task automatic put_word(input logic op, input t_pixel px, input bit fixed,
                            input t_pixel want);
        int phase;
        phase     = (words_sent / WORDS_PER_PHASE) % 4;
        idle_pct  = IDLE_PCT[phase];
        stall_pct = STALL_PCT[phase];
        while ($urandom_range(99) < idle_pct) begin
            src_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        src_if.valid <= 1'b1;
        src_if.op    <= op;
        src_if.blue  <= px[0];
        src_if.green <= px[1];
        src_if.red   <= px[2];
        word_fixed   <= fixed;
        word_want    <= want;
        do @(posedge i_clk); while (src_if.ready !== 1'b1);
        @(negedge i_clk);
        words_sent++;
    endtask

    // One register access: setup phase, access phase, then psel and penable dropped to idle
    task automatic reg_access(input logic wr, input int idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= 3'(idx * 4);
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        if (wr) begin
            if (idx == REG_WIDTH) cfg_width = wdata[WIDTH_W-1:0];
            else cfg_height = wdata[HEIGHT_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_reg(input int idx, input logic [31:0] want);
        logic [31:0] rdata;
        reg_access(1'b0, idx, '0, rdata);
        if (rdata !== want) begin
            $error("register %0d: expected %0d, got %0d", idx, want, rdata);
            failed = 1'b1;
        end
    endtask

    // Wait for every owed pixel, then for the pipeline to run dry
    task automatic settle_idle();
        while (pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write both size registers with junk above the field, then read them back
    task automatic set_size(input int w_val, input int h_val);
        logic [31:0] wdata;
        logic [31:0] rdata;
        settle_idle();
        wdata = $urandom;
        wdata[WIDTH_W-1:0] = WIDTH_W'(w_val);
        reg_access(1'b1, REG_WIDTH, wdata, rdata);
        wdata = $urandom;
        wdata[HEIGHT_W-1:0] = HEIGHT_W'(h_val);
        reg_access(1'b1, REG_HEIGHT, wdata, rdata);
        check_reg(REG_WIDTH, 32'(cfg_width));
        check_reg(REG_HEIGHT, 32'(cfg_height));
    endtask

    // Send one frame of random pixels and its drain, with some ignored words mixed in
    task automatic send_frame(input bit hold, input bit pause, output int words);
        int unsigned w, h, npx;
        w     = eff_width();
        h     = eff_height();
        npx   = w * h;
        words = npx + 2 * w + 2;
        if (hold) hold_left = HOLD_CYCLES;
        for (int unsigned k = 0; k < npx; k++) begin
            if (pause && k == npx / 2) begin
                src_if.valid <= 1'b0;
                while (pending.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            if ($urandom_range(31) == 0)
                put_word(OP_DRAIN, t_pixel'($urandom), 1'b0, '0);
            put_word(OP_PIXEL, random_pixel(), 1'b0, '0);
        end
        if ($urandom_range(2) == 0)
            repeat ($urandom_range(1, 2)) put_word(OP_PIXEL, random_pixel(), 1'b0, '0);
        repeat (2 * w + 2) put_word(OP_DRAIN, t_pixel'($urandom), 1'b0, '0);
        if ($urandom_range(2) == 0)
            put_word(OP_DRAIN, t_pixel'($urandom), 1'b0, '0);
        src_if.valid <= 1'b0;
    endtask

    initial begin
        int random_words;
        int frame_no;
        int n;
        src_if.valid = 1'b0;
        src_if.op    = OP_PIXEL;
        src_if.blue  = '0;
        src_if.green = '0;
        src_if.red   = '0;
        word_fixed   = 1'b0;
        word_want    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_rst_n      = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sizes after reset, then the smallest frame from the directed rows
        check_reg(REG_WIDTH, RESET_WIDTH);
        check_reg(REG_HEIGHT, RESET_HEIGHT);
        set_size(MIN_SIZE, MIN_SIZE);
        for (int r = 0; r < NUM_ROWS; r++)
            repeat (DIRECTED_ROWS[r].reps)
                put_word(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].pix,
                         DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].want);
        src_if.valid <= 1'b0;

        // Random small frames; the second one meets a long receiver hold-off,
        // the third pauses halfway until the block has caught up
        random_words = 0;
        frame_no     = 0;
        while (random_words < RANDOM_WORDS) begin
            set_size(($urandom_range(7) == 0) ? $urandom_range(4) : $urandom_range(5, 12),
                     ($urandom_range(7) == 0) ? $urandom_range(4) : $urandom_range(5, 9));
            send_frame(frame_no == 1, frame_no == 2, n);
            random_words += n;
            frame_no++;
        end

        // Size extremes: the registers keep the raw field values
        set_size(2047, 4095);
        set_size(0, 0);

        settle_idle();
        if (!failed) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
